// File: design/brle_pkg.sv
`default_nettype none

package brle_pkg;

  localparam int RunW     = 16;
  localparam int ByteBits = 8;
  localparam int NbW      = 4;
  localparam int MaxRes   = ByteBits + 1;
  localparam int ResCntW  = $clog2(MaxRes + 1);

  localparam logic [RunW-1:0] MaxRunsReset = 16'd512;
  localparam logic [NbW-1:0]  NbMax        = 4'(ByteBits);

  // register index of max_runs
  localparam logic RegMaxRuns = 1'b0;

  typedef struct packed {
    logic [RunW-1:0] count;
    logic            value;
    logic [RunW-1:0] emitted;
  } brle_state_t;

  typedef struct packed {
    logic [RunW-1:0] len;
    logic            last;
  } brle_run_t;

  typedef struct packed {
    brle_run_t [MaxRes-1:0] runs;
    logic [ResCntW-1:0]     n_runs;
    brle_state_t            state;
  } brle_step_t;

  localparam brle_state_t StateReset = '{count: '0, value: 1'b1, emitted: '0};

endpackage

`default_nettype wire

// File: design/bitmap_run_length_encoder.sv
// channel  dir  handshake           payload
// in_      in   tvalid/tready       tdata[7:0] bit_byte, [11:8] valid_bits; tlast end_of_bitmap
// out_     out  tvalid/tready       tdata[15:0] run_length; tlast last_run
// cfg_     in   apb, pready high    reg 0 at 0x0: max_runs[15:0]
//
// each input beat is folded into the run state in its accept cycle and its
// runs (up to nine) land in a result buffer that drains one beat per cycle
// while out_tready is high. a new byte is taken when the buffer is empty or
// sends its last run now, so the output drain sets the pace of input bytes.
// rst_n is synchronous: run state cleared, max_runs back to 512.

`default_nettype none

module bitmap_run_length_encoder
  import brle_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // bit_byte[7:0], valid_bits[11:8], zero pad
  input  wire         in_tlast,

  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // run_length[15:0]
  output logic        out_tlast,

  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  brle_state_t              state_r, state_nxt;
  logic [RunW-1:0]          max_runs_r, max_runs_nxt;
  brle_run_t [MaxRes-1:0]   buf_r, buf_nxt;
  logic [ResCntW-1:0]       cnt_r, cnt_nxt;
  brle_step_t               step;
  logic                     accept;
  logic                     pop;
  logic                     cfg_wr;

  brle_step u_step (
    .cur           (state_r),
    .max_runs      (max_runs_r),
    .bit_byte      (in_tdata[7:0]),
    .valid_bits    (in_tdata[11:8]),
    .end_of_bitmap (in_tlast),
    .res           (step)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == RegMaxRuns) ? {16'd0, max_runs_r} : 32'd0;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[0].len;
  assign out_tlast  = buf_r[0].last;
  assign pop        = out_tvalid && out_tready;

  // take a byte when the buffer is empty or its final run leaves this cycle
  assign in_tready  = (cnt_r == '0) || ((cnt_r == ResCntW'(1)) && out_tready);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    state_nxt = state_r;
    max_runs_nxt = max_runs_r;
    if (accept) begin
      buf_nxt = step.runs;
      cnt_nxt = step.n_runs;
      state_nxt = step.state;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cfg_wr && cfg_paddr[2] == RegMaxRuns) begin
      max_runs_nxt = cfg_pwdata[RunW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      state_r <= StateReset;
      max_runs_r <= MaxRunsReset;
    end else begin
      cnt_r <= cnt_nxt;
      state_r <= state_nxt;
      max_runs_r <= max_runs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

`default_nettype wire

// File: design/brle_step.sv
`default_nettype none

module brle_step
  import brle_pkg::*;
(
  input  wire brle_state_t     cur,
  input  wire [RunW-1:0]       max_runs,
  input  wire [ByteBits-1:0]   bit_byte,
  input  wire [NbW-1:0]        valid_bits,
  input  wire                  end_of_bitmap,
  output brle_step_t           res
);

  logic [NbW-1:0]     nb;
  logic [RunW-1:0]    room;
  logic [NbW-1:0]     allowed;
  logic [NbW-1:0]     n_emit;
  logic [NbW-1:0]     cnt;
  logic [NbW-1:0]     lead;
  logic               val;
  logic [RunW-1:0]    open_len;

  always_comb begin
    nb = (valid_bits > NbMax) ? NbMax : valid_bits;
    room = max_runs - cur.emitted;
    if (cur.emitted >= max_runs) begin
      allowed = '0;
    end else if (room > RunW'(ByteBits)) begin
      allowed = NbMax;
    end else begin
      allowed = room[NbW-1:0];
    end

    res = '0;
    n_emit = '0;
    cnt = '0;
    lead = '0;
    val = cur.value;

    // bits of the open run seen in this byte live in cnt; the first close
    // of the byte also closes the run carried in from earlier bytes
    for (int i = 0; i < ByteBits; i++) begin
      if (NbW'(i) < nb && n_emit != allowed) begin
        if (bit_byte[i] == val) begin
          cnt = cnt + 1'b1;
        end else begin
          if (n_emit == '0) begin
            lead = cnt;
          end else begin
            res.runs[n_emit[NbW-1:0]].len = RunW'(cnt);
          end
          n_emit = n_emit + 1'b1;
          cnt = NbW'(1);
          val = bit_byte[i];
        end
      end
    end

    if (n_emit != '0) begin
      res.runs[0].len = cur.count + RunW'(lead);
    end
    open_len = (n_emit == '0) ? cur.count + RunW'(cnt) : RunW'(cnt);

    if (end_of_bitmap) begin
      res.runs[n_emit].len = open_len;
      res.runs[n_emit].last = 1'b1;
      res.n_runs = ResCntW'(n_emit) + 1'b1;
      res.state = StateReset;
    end else begin
      res.n_runs = ResCntW'(n_emit);
      res.state.count = open_len;
      res.state.value = val;
      res.state.emitted = cur.emitted + RunW'(n_emit);
    end
  end

endmodule

`default_nettype wire
